>>> design/alps_pkg.sv
// alps_pkg: shared types and constants of the ambient light power save controller
// used by every module of the block, no dependencies
`timescale 1ns / 1ps

package alps_pkg;

  // item codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_BUTTON = 2'd1;
  localparam logic [1:0] FUNC_END    = 2'd2;

  // save mode codes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_SMART  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_ENABLE       = 3'd0;
  localparam logic [2:0] CFG_DARK_THRESH  = 3'd1;
  localparam logic [2:0] CFG_BRIGHT_THRESH = 3'd2;
  localparam logic [2:0] CFG_DWELL        = 3'd3;
  localparam logic [2:0] CFG_IDLE_TIMEOUT = 3'd4;
  localparam logic [2:0] CFG_IDLE_CHECK   = 3'd5;
  localparam logic [2:0] CFG_LONG_IDLE    = 3'd6;
  localparam logic [2:0] CFG_WEEK         = 3'd7;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [1:0]  RST_ENABLE       = 2'd3;
  localparam logic [7:0]  RST_DARK_THRESH  = 8'd50;
  localparam logic [7:0]  RST_BRIGHT_THRESH = 8'd80;
  localparam logic [15:0] RST_DWELL        = 16'd600;
  localparam logic [7:0]  RST_IDLE_TIMEOUT = 8'd9;
  localparam logic [7:0]  RST_IDLE_CHECK   = 8'd16;
  localparam logic [7:0]  RST_LONG_IDLE    = 8'd84;
  localparam logic [7:0]  RST_WEEK         = 8'd168;

  // time base and weekly decision limits
  localparam logic [5:0]  SEC_PER_MIN     = 6'd60;
  localparam logic [5:0]  MIN_PER_HOUR    = 6'd60;
  localparam logic [11:0] SEC_PER_HOUR    = 12'd3600;
  localparam logic [7:0]  EPISODE_MAX     = 8'hFF;
  localparam logic [7:0]  EPISODE_INTENSE = 8'd2;
  localparam logic [7:0]  EPISODE_GREEN   = 8'd4;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] light_sample;
    logic       sensor_fault;
    logic       button_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] save_mode;
    logic       is_dark;
    logic       intensive_week;
    logic [7:0] idle_hours;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  enable_bits;
    logic [7:0]  dark_threshold;
    logic [7:0]  bright_threshold;
    logic [15:0] dwell_seconds;
    logic [7:0]  idle_timeout_hours;
    logic [7:0]  idle_check_hours;
    logic [7:0]  long_idle_hours;
    logic [7:0]  week_hours;
  } cfg_t;

  // status after the current transaction, from the save controller
  typedef struct packed {
    logic [1:0] mode;
    logic       week_type;
    logic [7:0] idle_hours;
    logic       clear_light;
  } save_status_t;

endpackage

>>> design/ambient_light_power_save_controller_top.sv
// ambient light power save controller: input register, single pass update, result register
// the input register feeds the result register, so each result is registered
// throughput: one transaction per cycle if unstalled; the whole update is one combinational pass
// reset: synchronous active-high rst restores config, valid flags and state to their defaults
// depends on alps_pkg, alps_light_qual, alps_save_ctrl
`timescale 1ns / 1ps

module ambient_light_power_save_controller_top
  import alps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  cfg_t         cfg;
  logic         s1_valid;
  in_item_t     s1_data;
  logic         advance;
  logic         dark_next;
  save_status_t status;

  // stage 1 moves into the result register when that register is free or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_bits        <= RST_ENABLE;
      cfg.dark_threshold     <= RST_DARK_THRESH;
      cfg.bright_threshold   <= RST_BRIGHT_THRESH;
      cfg.dwell_seconds      <= RST_DWELL;
      cfg.idle_timeout_hours <= RST_IDLE_TIMEOUT;
      cfg.idle_check_hours   <= RST_IDLE_CHECK;
      cfg.long_idle_hours    <= RST_LONG_IDLE;
      cfg.week_hours         <= RST_WEEK;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_ENABLE:        cfg.enable_bits        <= cfg_wr_data[1:0];
        CFG_DARK_THRESH:   cfg.dark_threshold     <= cfg_wr_data[7:0];
        CFG_BRIGHT_THRESH: cfg.bright_threshold   <= cfg_wr_data[7:0];
        CFG_DWELL:         cfg.dwell_seconds      <= cfg_wr_data;
        CFG_IDLE_TIMEOUT:  cfg.idle_timeout_hours <= cfg_wr_data[7:0];
        CFG_IDLE_CHECK:    cfg.idle_check_hours   <= cfg_wr_data[7:0];
        CFG_LONG_IDLE:     cfg.long_idle_hours    <= cfg_wr_data[7:0];
        CFG_WEEK:          cfg.week_hours         <= cfg_wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  alps_light_qual u_light (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .tick      (s1_data.func == FUNC_TICK),
    .clear     (status.clear_light),
    .sample    (s1_data.light_sample),
    .cfg       (cfg),
    .dark_next (dark_next)
  );

  alps_save_ctrl u_save (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s1_data),
    .dark   (dark_next),
    .cfg    (cfg),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.save_mode      <= status.mode;
      out_data.is_dark        <= dark_next;
      out_data.intensive_week <= status.week_type;
      out_data.idle_hours     <= status.idle_hours;
    end
  end

endmodule

>>> design/alps_light_qual.sv
// alps_light_qual: dark/bright qualification with hysteresis band and dwell timer
// depends on alps_pkg
`timescale 1ns / 1ps

module alps_light_qual
  import alps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        tick,
  input  logic        clear,
  input  logic [7:0]  sample,
  input  cfg_t        cfg,
  output logic        dark_next
);

  logic        dark_state;
  logic [15:0] dark_timer;
  logic [15:0] bright_timer;
  logic [15:0] dark_timer_next;
  logic [15:0] bright_timer_next;

  always_comb begin
    dark_next         = dark_state;
    dark_timer_next   = dark_timer;
    bright_timer_next = bright_timer;
    if (clear) begin
      dark_next         = 1'b0;
      dark_timer_next   = '0;
      bright_timer_next = '0;
    end else if (tick) begin
      // dark test wins when thresholds overlap
      if (sample < cfg.dark_threshold) begin
        bright_timer_next = '0;
        if (!dark_state) begin
          if (dark_timer >= cfg.dwell_seconds) begin
            dark_timer_next = '0;
            dark_next       = 1'b1;
          end else begin
            dark_timer_next = dark_timer + 16'd1;
          end
        end
      end else if (sample > cfg.bright_threshold) begin
        dark_timer_next = '0;
        if (dark_state) begin
          if (bright_timer >= cfg.dwell_seconds) begin
            bright_timer_next = '0;
            dark_next         = 1'b0;
          end else begin
            bright_timer_next = bright_timer + 16'd1;
          end
        end
      end else begin
        dark_timer_next   = '0;
        bright_timer_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_state   <= 1'b0;
      dark_timer   <= '0;
      bright_timer <= '0;
    end else if (step) begin
      dark_state   <= dark_next;
      dark_timer   <= dark_timer_next;
      bright_timer <= bright_timer_next;
    end
  end

endmodule

>>> design/alps_save_ctrl.sv
// alps_save_ctrl: normal and smart no-use save modes, idle time and weekly decision
// depends on alps_pkg
`timescale 1ns / 1ps

module alps_save_ctrl
  import alps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  in_item_t     item,
  input  logic         dark,
  input  cfg_t         cfg,
  output save_status_t status
);

  logic [1:0]  mode_reg;
  logic        prior_dark;
  logic [5:0]  idle_seconds;
  logic [5:0]  idle_minutes;
  logic [7:0]  idle_hour_count;
  logic [11:0] hour_prescaler;
  logic        button_seen;
  logic [7:0]  check_countdown;
  logic [7:0]  long_countdown;
  logic [7:0]  week_countdown;
  logic        week_type;
  logic [7:0]  idle_episodes;

  logic [1:0]  mode_next;
  logic        prior_dark_next;
  logic [5:0]  idle_seconds_next;
  logic [5:0]  idle_minutes_next;
  logic [7:0]  idle_hour_count_next;
  logic [11:0] hour_prescaler_next;
  logic        button_seen_next;
  logic [7:0]  check_countdown_next;
  logic [7:0]  long_countdown_next;
  logic [7:0]  week_countdown_next;
  logic        week_type_next;
  logic [7:0]  idle_episodes_next;
  logic        clear_idle_a;
  logic        clear_idle_b;
  logic        clear_idle_c;
  logic [5:0]  sec_inc;
  logic [5:0]  min_inc;
  logic [11:0] pre_inc;

  always_comb begin
    mode_next            = mode_reg;
    prior_dark_next      = prior_dark;
    idle_seconds_next    = idle_seconds;
    idle_minutes_next    = idle_minutes;
    idle_hour_count_next = idle_hour_count;
    hour_prescaler_next  = hour_prescaler;
    button_seen_next     = button_seen;
    check_countdown_next = check_countdown;
    long_countdown_next  = long_countdown;
    week_countdown_next  = week_countdown;
    week_type_next       = week_type;
    idle_episodes_next   = idle_episodes;
    clear_idle_a         = 1'b0;
    clear_idle_b         = 1'b0;
    clear_idle_c         = 1'b0;
    sec_inc              = idle_seconds + 6'd1;
    min_inc              = idle_minutes + 6'd1;
    pre_inc              = hour_prescaler + 12'd1;
    status.clear_light   = 1'b0;

    case (item.func)
      FUNC_TICK: begin
        // normal save on qualified darkness
        if (cfg.enable_bits[0]) begin
          if (mode_reg == MODE_NONE) begin
            if (dark) begin
              prior_dark_next = 1'b1;
              mode_next       = MODE_NORMAL;
            end
          end else if (!dark) begin
            prior_dark_next = 1'b0;
            mode_next       = MODE_NONE;
            clear_idle_a    = 1'b1;
          end
        end else begin
          if (mode_reg == MODE_NORMAL) mode_next = MODE_NONE;
          if (dark) begin
            prior_dark_next = 1'b1;
          end else if (prior_dark) begin
            mode_next    = MODE_NONE;
            clear_idle_a = 1'b1;
          end
        end
        if (clear_idle_a) begin
          idle_seconds_next    = '0;
          idle_minutes_next    = '0;
          idle_hour_count_next = '0;
        end

        // idle time count
        if (week_type) begin
          if (mode_next == MODE_SMART) mode_next = MODE_NONE;
          idle_seconds_next    = '0;
          idle_minutes_next    = '0;
          idle_hour_count_next = '0;
        end else if (idle_hour_count_next < cfg.idle_timeout_hours) begin
          sec_inc = idle_seconds_next + 6'd1;
          min_inc = idle_minutes_next + 6'd1;
          if (sec_inc >= SEC_PER_MIN) begin
            idle_seconds_next = '0;
            if (min_inc >= MIN_PER_HOUR) begin
              idle_minutes_next    = '0;
              idle_hour_count_next = idle_hour_count_next + 8'd1;
            end else begin
              idle_minutes_next = min_inc;
            end
          end else begin
            idle_seconds_next = sec_inc;
          end
        end else begin
          idle_seconds_next = '0;
          idle_minutes_next = '0;
        end

        // hourly countdowns and weekly decision
        if (pre_inc < SEC_PER_HOUR) begin
          hour_prescaler_next = pre_inc;
        end else begin
          hour_prescaler_next = '0;
          if (week_countdown != 8'd0) week_countdown_next = week_countdown - 8'd1;
          if (check_countdown != 8'd0) check_countdown_next = check_countdown - 8'd1;
          if (long_countdown != 8'd0) long_countdown_next = long_countdown - 8'd1;
          if (week_countdown_next == 8'd0) begin
            if (long_countdown_next == 8'd0) week_type_next = 1'b0;
            else if (idle_episodes <= EPISODE_INTENSE) week_type_next = 1'b1;
            else if (idle_episodes >= EPISODE_GREEN) week_type_next = 1'b0;
            if (mode_next == MODE_SMART) mode_next = MODE_NONE;
            clear_idle_b         = 1'b1;
            button_seen_next     = 1'b0;
            check_countdown_next = cfg.idle_check_hours;
            long_countdown_next  = cfg.long_idle_hours;
            week_countdown_next  = cfg.week_hours;
            idle_episodes_next   = '0;
          end else if (button_seen) begin
            if (check_countdown_next == 8'd0 && idle_episodes < EPISODE_MAX) begin
              idle_episodes_next = idle_episodes + 8'd1;
            end
            check_countdown_next = cfg.idle_check_hours;
            long_countdown_next  = cfg.long_idle_hours;
            button_seen_next     = 1'b0;
          end else if (long_countdown_next == 8'd0) begin
            week_type_next = 1'b0;
          end
        end
        if (clear_idle_b) begin
          idle_seconds_next    = '0;
          idle_minutes_next    = '0;
          idle_hour_count_next = '0;
        end

        // smart no-use save
        if (item.sensor_fault) begin
          if (mode_next == MODE_SMART) mode_next = MODE_NONE;
          clear_idle_c = 1'b1;
        end else if (cfg.enable_bits[1]) begin
          if (mode_next != MODE_SMART) begin
            if (idle_hour_count_next >= cfg.idle_timeout_hours) begin
              mode_next    = MODE_SMART;
              clear_idle_c = 1'b1;
            end
          end else begin
            clear_idle_c = 1'b1;
          end
        end else begin
          if (mode_next == MODE_SMART) mode_next = MODE_NONE;
          clear_idle_c         = 1'b1;
          button_seen_next     = 1'b0;
          hour_prescaler_next  = '0;
          check_countdown_next = cfg.idle_check_hours;
          long_countdown_next  = cfg.long_idle_hours;
          week_type_next       = 1'b0;
          week_countdown_next  = cfg.week_hours;
          idle_episodes_next   = '0;
        end
        if (clear_idle_c) begin
          idle_seconds_next    = '0;
          idle_minutes_next    = '0;
          idle_hour_count_next = '0;
        end
      end
      FUNC_BUTTON: begin
        button_seen_next = item.button_value;
      end
      FUNC_END: begin
        if (mode_reg != MODE_NONE) begin
          mode_next          = MODE_NONE;
          prior_dark_next    = 1'b0;
          status.clear_light = 1'b1;
        end
      end
      default: begin
        // unused code leaves the state alone
      end
    endcase

    status.mode       = mode_next;
    status.week_type  = week_type_next;
    status.idle_hours = idle_hour_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= MODE_NONE;
      prior_dark      <= 1'b0;
      idle_seconds    <= '0;
      idle_minutes    <= '0;
      idle_hour_count <= '0;
      hour_prescaler  <= '0;
      button_seen     <= 1'b0;
      check_countdown <= RST_IDLE_CHECK;
      long_countdown  <= RST_LONG_IDLE;
      week_countdown  <= RST_WEEK;
      week_type       <= 1'b0;
      idle_episodes   <= '0;
    end else if (step) begin
      mode_reg        <= mode_next;
      prior_dark      <= prior_dark_next;
      idle_seconds    <= idle_seconds_next;
      idle_minutes    <= idle_minutes_next;
      idle_hour_count <= idle_hour_count_next;
      hour_prescaler  <= hour_prescaler_next;
      button_seen     <= button_seen_next;
      check_countdown <= check_countdown_next;
      long_countdown  <= long_countdown_next;
      week_countdown  <= week_countdown_next;
      week_type       <= week_type_next;
      idle_episodes   <= idle_episodes_next;
    end
  end

endmodule

>>> test/tb_ambient_light_power_save_controller_top.sv
// testbench for ambient_light_power_save_controller_top: directed, random and long-stretch
// stimulus, with a scoreboard class that predicts each status result and checks it field by field
// depends on alps_pkg and the controller RTL
`timescale 1ns / 1ps

module tb_ambient_light_power_save_controller_top;
  import alps_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned IDLE_PCT = 18;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned RAND_ITEMS = 270;
  localparam int unsigned SOAK_PHASES = 3;
  localparam int unsigned SOAK_ITEMS = 120;

  class power_save_scoreboard;
    cfg_t regs;
    bit dark_st, prior_dark;
    logic [15:0] dark_tmr, bright_tmr;
    logic [1:0] mode;
    int unsigned idle_sec, idle_min;
    logic [7:0] idle_hrs;
    logic [11:0] hour_pre;
    bit btn_seen, intensive;
    logic [7:0] check_cd, long_cd, week_cd, episodes;
    out_item_t expected_status_q[$];
    int unsigned mismatches, inputs, results, normal_seen, smart_seen, intensive_seen;

    function new();
      regs = '{RST_ENABLE, RST_DARK_THRESH, RST_BRIGHT_THRESH, RST_DWELL, RST_IDLE_TIMEOUT,
               RST_IDLE_CHECK, RST_LONG_IDLE, RST_WEEK};
      dark_st = 0;
      prior_dark = 0;
      dark_tmr = '0;
      bright_tmr = '0;
      mode = MODE_NONE;
      clear_idle();
      hour_pre = '0;
      btn_seen = 0;
      check_cd = RST_IDLE_CHECK;
      long_cd = RST_LONG_IDLE;
      week_cd = RST_WEEK;
      intensive = 0;
      episodes = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_ENABLE:        regs.enable_bits = val[1:0];
        CFG_DARK_THRESH:   regs.dark_threshold = val[7:0];
        CFG_BRIGHT_THRESH: regs.bright_threshold = val[7:0];
        CFG_DWELL:         regs.dwell_seconds = val;
        CFG_IDLE_TIMEOUT:  regs.idle_timeout_hours = val[7:0];
        CFG_IDLE_CHECK:    regs.idle_check_hours = val[7:0];
        CFG_LONG_IDLE:     regs.long_idle_hours = val[7:0];
        CFG_WEEK:          regs.week_hours = val[7:0];
        default: ;
      endcase
    endfunction

    function void clear_idle();
      idle_sec = 0;
      idle_min = 0;
      idle_hrs = '0;
    endfunction

    function int unsigned pending();
      return expected_status_q.size();
    endfunction

    function void predict_transaction(in_item_t it);
      out_item_t exp;
      inputs++;
      case (it.func)
        FUNC_TICK: begin
          // light qualification, dark test wins when thresholds overlap
          if (it.light_sample < regs.dark_threshold) begin
            bright_tmr = '0;
            if (!dark_st) begin
              if (dark_tmr >= regs.dwell_seconds) begin
                dark_tmr = '0;
                dark_st = 1;
              end else dark_tmr = dark_tmr + 16'd1;
            end
          end else if (it.light_sample > regs.bright_threshold) begin
            dark_tmr = '0;
            if (dark_st) begin
              if (bright_tmr >= regs.dwell_seconds) begin
                bright_tmr = '0;
                dark_st = 0;
              end else bright_tmr = bright_tmr + 16'd1;
            end
          end else begin
            dark_tmr = '0;
            bright_tmr = '0;
          end
          // normal save
          if (regs.enable_bits[0]) begin
            if (mode == MODE_NONE) begin
              if (dark_st) begin
                prior_dark = 1;
                mode = MODE_NORMAL;
              end
            end else if (!dark_st) begin
              prior_dark = 0;
              mode = MODE_NONE;
              clear_idle();
            end
          end else begin
            if (mode == MODE_NORMAL) mode = MODE_NONE;
            if (dark_st) prior_dark = 1;
            else if (prior_dark) begin
              mode = MODE_NONE;
              clear_idle();
            end
          end
          // idle time count
          if (intensive) begin
            if (mode == MODE_SMART) mode = MODE_NONE;
            clear_idle();
          end else if (idle_hrs < regs.idle_timeout_hours) begin
            idle_sec++;
            if (idle_sec >= SEC_PER_MIN) begin
              idle_sec = 0;
              idle_min++;
              if (idle_min >= MIN_PER_HOUR) begin
                idle_min = 0;
                idle_hrs = idle_hrs + 8'd1;
              end
            end
          end else begin
            idle_sec = 0;
            idle_min = 0;
          end
          // hourly countdowns and weekly choice
          hour_pre = hour_pre + 12'd1;
          if (hour_pre >= SEC_PER_HOUR) begin
            hour_pre = '0;
            if (week_cd != 0) week_cd--;
            if (check_cd != 0) check_cd--;
            if (long_cd != 0) long_cd--;
            if (week_cd == 0) begin
              if (long_cd == 0) intensive = 0;
              else if (episodes <= EPISODE_INTENSE) intensive = 1;
              else if (episodes >= EPISODE_GREEN) intensive = 0;
              if (mode == MODE_SMART) mode = MODE_NONE;
              clear_idle();
              btn_seen = 0;
              check_cd = regs.idle_check_hours;
              long_cd = regs.long_idle_hours;
              week_cd = regs.week_hours;
              episodes = '0;
            end else if (btn_seen) begin
              if (check_cd == 0 && episodes < EPISODE_MAX) episodes++;
              check_cd = regs.idle_check_hours;
              long_cd = regs.long_idle_hours;
              btn_seen = 0;
            end else if (long_cd == 0) intensive = 0;
          end
          // smart no-use save
          if (it.sensor_fault) begin
            if (mode == MODE_SMART) mode = MODE_NONE;
            clear_idle();
          end else if (regs.enable_bits[1]) begin
            if (mode != MODE_SMART) begin
              if (idle_hrs >= regs.idle_timeout_hours) begin
                mode = MODE_SMART;
                clear_idle();
              end
            end else clear_idle();
          end else begin
            if (mode == MODE_SMART) mode = MODE_NONE;
            clear_idle();
            btn_seen = 0;
            hour_pre = '0;
            check_cd = regs.idle_check_hours;
            long_cd = regs.long_idle_hours;
            intensive = 0;
            week_cd = regs.week_hours;
            episodes = '0;
          end
        end
        FUNC_BUTTON: btn_seen = it.button_value;
        FUNC_END: begin
          if (mode != MODE_NONE) begin
            mode = MODE_NONE;
            prior_dark = 0;
            dark_st = 0;
            bright_tmr = '0;
            dark_tmr = '0;
          end
        end
        default: ;
      endcase
      exp.save_mode = mode;
      exp.is_dark = dark_st;
      exp.intensive_week = intensive;
      exp.idle_hours = idle_hrs;
      expected_status_q.push_back(exp);
    endfunction

    function void check_status(out_item_t got);
      out_item_t exp;
      results++;
      if (got.save_mode == MODE_NORMAL) normal_seen++;
      if (got.save_mode == MODE_SMART) smart_seen++;
      if (got.intensive_week) intensive_seen++;
      if (expected_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: status result with no transaction pending: %s %0d %0b %0b %0d",
                   $time, "mode/dark/week/idle", got.save_mode, got.is_dark,
                   got.intensive_week, got.idle_hours);
        return;
      end
      exp = expected_status_q.pop_front();
      if (got.save_mode !== exp.save_mode || got.is_dark !== exp.is_dark ||
          got.intensive_week !== exp.intensive_week || got.idle_hours !== exp.idle_hours) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d mismatch: mode %0d/%0d dark %0b/%0b week %0b/%0b idle %0d/%0d",
                   $time, results, exp.save_mode, got.save_mode, exp.is_dark, got.is_dark,
                   exp.intensive_week, got.intensive_week, exp.idle_hours, got.idle_hours);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  power_save_scoreboard sb;
  bit no_idle = 0;
  int unsigned light_regime = 2;
  int unsigned stale_cycles = 0;
  int unsigned settings_used = 0;

  ambient_light_power_save_controller_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr(cfg_addr),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  // sample both channels on the edge, before any update lands
  always @(posedge clk) begin
    if (rst) begin
      stale_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check_status(out_data);
      if (in_valid && !in_stall) sb.predict_transaction(in_data);
      stale_cycles <= ((out_valid && !out_stall) || (in_valid && !in_stall)) ?
                      0 : stale_cycles + 1;
    end
  end

  initial begin
    wait (stale_cycles >= STALL_LIMIT);
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic in_item_t mk(logic [1:0] func, logic [7:0] light, logic fault, logic btn);
    in_item_t it;
    it.func = func;
    it.light_sample = light;
    it.sensor_fault = fault;
    it.button_value = btn;
    return it;
  endfunction

  function automatic logic [7:0] biased_byte();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // light follows a regime (dark, bright or anywhere) that changes now and then
  function automatic logic [7:0] light_value();
    logic [7:0] dk = sb.regs.dark_threshold;
    logic [7:0] br = sb.regs.bright_threshold;
    case (light_regime)
      0: return (dk == 0) ? 8'd0 : 8'($urandom_range(dk - 1));
      1: return (br == 255) ? 8'd255 : 8'($urandom_range(255, br + 1));
      default: return 8'($urandom);
    endcase
  endfunction

  // rates in parts per million
  function automatic in_item_t gen_item(int unsigned btn_ppm, int unsigned end_ppm,
                                        int unsigned odd_ppm, int unsigned fault_ppm,
                                        int unsigned switch_ppm);
    in_item_t it;
    int unsigned r;
    if ($urandom_range(999999) < switch_ppm) light_regime = $urandom_range(2);
    r = $urandom_range(999999);
    it.light_sample = light_value();
    it.sensor_fault = ($urandom_range(999999) < fault_ppm);
    it.button_value = 1'($urandom);
    if (r < btn_ppm) it.func = FUNC_BUTTON;
    else if (r < btn_ppm + end_ppm) it.func = FUNC_END;
    else if (r < btn_ppm + end_ppm + odd_ppm) it.func = FUNC_UNUSED;
    else it.func = FUNC_TICK;
    return it;
  endfunction

  task automatic send(input in_item_t it);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // advance the clock first so the last accepted transaction is already in the scoreboard
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wr_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // narrow registers get random upper data bits, which must be dropped
  task automatic config_regs(input logic [1:0] en, input logic [7:0] dk, input logic [7:0] br,
                             input logic [15:0] dwell, input logic [7:0] timeout,
                             input logic [7:0] check, input logic [7:0] long_idle,
                             input logic [7:0] week);
    put_reg(CFG_ENABLE, {14'($urandom), en});
    put_reg(CFG_DARK_THRESH, {8'($urandom), dk});
    put_reg(CFG_BRIGHT_THRESH, {8'($urandom), br});
    put_reg(CFG_DWELL, dwell);
    put_reg(CFG_IDLE_TIMEOUT, {8'($urandom), timeout});
    put_reg(CFG_IDLE_CHECK, {8'($urandom), check});
    put_reg(CFG_LONG_IDLE, {8'($urandom), long_idle});
    put_reg(CFG_WEEK, {8'($urandom), week});
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int unsigned errors;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: field extremes, threshold edges, every operation
    send(mk(FUNC_TICK, 8'd0, 1'b0, 1'b0));
    send(mk(FUNC_TICK, 8'd255, 1'b0, 1'b1));
    send(mk(FUNC_TICK, 8'd50, 1'b0, 1'b0));
    send(mk(FUNC_TICK, 8'd80, 1'b0, 1'b0));
    send(mk(FUNC_BUTTON, 8'd0, 1'b0, 1'b1));
    send(mk(FUNC_BUTTON, 8'd255, 1'b1, 1'b0));
    send(mk(FUNC_UNUSED, 8'd255, 1'b1, 1'b1));
    send(mk(FUNC_END, 8'd0, 1'b0, 1'b0));
    send(mk(FUNC_TICK, 8'd49, 1'b1, 1'b0));
    drain();

    // overlapping thresholds, no dwell, immediate smart save
    config_regs(2'd3, 8'd200, 8'd10, 16'd0, 8'd0, 8'd0, 8'd0, 8'd1);
    send(mk(FUNC_TICK, 8'd100, 1'b0, 1'b0));
    send(mk(FUNC_TICK, 8'd255, 1'b0, 1'b0));
    send(mk(FUNC_END, 8'd0, 1'b0, 1'b0));
    send(mk(FUNC_TICK, 8'd0, 1'b1, 1'b0));
    send(mk(FUNC_UNUSED, 8'd0, 1'b0, 1'b0));
    drain();

    // normal save disabled: dark then bright keeps clearing the mode and idle time
    config_regs(2'd2, 8'd50, 8'd80, 16'd0, 8'd255, 8'd16, 8'd84, 8'd168);
    send(mk(FUNC_TICK, 8'd0, 1'b0, 1'b0));
    send(mk(FUNC_TICK, 8'd255, 1'b0, 1'b0));
    send(mk(FUNC_TICK, 8'd255, 1'b0, 1'b0));
    send(mk(FUNC_TICK, 8'd65, 1'b0, 1'b0));
    drain();

    // both saves disabled
    config_regs(2'd0, 8'd50, 8'd80, 16'd0, 8'd9, 8'd16, 8'd84, 8'd168);
    send(mk(FUNC_TICK, 8'd0, 1'b0, 1'b0));
    send(mk(FUNC_TICK, 8'd255, 1'b0, 1'b0));
    send(mk(FUNC_END, 8'd0, 1'b0, 1'b0));
    drain();

    // random mix; first two settings are the all-zero and all-max extremes
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) config_regs(2'd0, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      else if (p == 1)
        config_regs(2'd3, 8'd255, 8'd255, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255);
      else config_regs(2'($urandom_range(3)), biased_byte(), biased_byte(),
                       16'($urandom_range(4)), 8'($urandom_range(3)), biased_byte(),
                       biased_byte(), biased_byte());
      no_idle = (p == 2);
      for (int n = 0; n < RAND_ITEMS; n++) begin
        send(gen_item(120000, 60000, 70000, 50000, 50000));
        if (p == 3 && n == RAND_ITEMS / 2) drain();
      end
      drain();
    end
    no_idle = 0;

    // long light stretches and rare buttons, so the dwell timers and idle count play out
    for (int s = 0; s < SOAK_PHASES; s++) begin
      config_regs((s == 2) ? 2'd2 : 2'd3, 8'($urandom_range(30, 60)),
                  8'($urandom_range(70, 100)),
                  16'($urandom_range(1, 5)), 8'($urandom_range(2)), 8'($urandom_range(2)),
                  (s == 1) ? 8'($urandom_range(1, 3)) : 8'd255, 8'($urandom_range(2, 5)));
      light_regime = $urandom_range(2);
      for (int n = 0; n < SOAK_ITEMS; n++)
        send(gen_item(1300, 150, 2000, 100, 250));
      drain();
    end

    errors = sb.mismatches + sb.pending();
    $display("%0d transactions in, %0d results checked, over %0d register settings",
             sb.inputs, sb.results, settings_used);
    $display("results in normal save %0d, smart save %0d, intensive week %0d",
             sb.normal_seen, sb.smart_seen, sb.intensive_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
